@@ design/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ design/pstb_pkg.sv @@
package pstb_pkg;
   localparam int TABLE_ENTRIES = 64;
   localparam int TOKEN_FRACTION_BITS = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 2);
   localparam logic [32:0] ONE_TOKEN = 33'(64'd1 << TOKEN_FRACTION_BITS);

   typedef enum logic [1:0] {
      CSR_LIMIT_ENABLE = 2'd0,
      CSR_REFILL_RATE  = 2'd1,
      CSR_BURST_LIMIT  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_DONE
   } state_type;

   // Search request travelling along the row of cells.
   typedef struct packed {
      logic        active;
      logic        found;
      logic [IDX_W-1:0] hit_idx;
      logic        has_free;
      logic [IDX_W-1:0] free_idx;
      logic [31:0] tokens;
      logic [31:0] stamp;
   } scan_type;

   // Write command broadcast to the cells.
   typedef struct packed {
      logic        we;
      logic [IDX_W-1:0] idx;
      logic        new_key;
      logic [31:0] tokens;
      logic [31:0] stamp;
   } upd_type;
endpackage

@@ design/pstb_cell.sv @@
module pstb_cell import pstb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] my_idx,
   input  logic [7:0]       key_fam,
   input  logic [63:0]      key_hi,
   input  logic [63:0]      key_lo,
   input  scan_type         scan_i,
   output scan_type         scan_o,
   input  upd_type          upd
);
   logic        valid_ff;
   logic [7:0]  fam_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [31:0] tok_ff, stamp_ff;
   scan_type    scan_ff, scan_in;
   logic        match;

   assign match = valid_ff && fam_ff == key_fam && hi_ff == key_hi && lo_ff == key_lo;

   always_comb begin
      scan_in = scan_i;
      if (scan_i.active) begin
         if (match && !scan_i.found) begin
            scan_in.found = 1'b1;
            scan_in.hit_idx = my_idx;
            scan_in.tokens = tok_ff;
            scan_in.stamp = stamp_ff;
         end
         if (!valid_ff && !scan_i.has_free) begin
            scan_in.has_free = 1'b1;
            scan_in.free_idx = my_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         scan_ff.active <= 1'b0;
      end else begin
         scan_ff <= scan_in;
         if (upd.we && upd.idx == my_idx) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.we && upd.idx == my_idx) begin
         tok_ff <= upd.tokens;
         stamp_ff <= upd.stamp;
         if (upd.new_key) begin
            fam_ff <= key_fam;
            hi_ff <= key_hi;
            lo_ff <= key_lo;
         end
      end
   end

   assign scan_o = scan_ff;
endmodule

@@ design/pstb_refill.sv @@
module pstb_refill import pstb_pkg::*; (
   input  logic        clock,
   input  logic [31:0] rate,
   input  logic [31:0] burst,
   input  logic [31:0] tokens,
   input  logic [31:0] stamp,
   input  logic [31:0] now,
   input  logic        load,
   output logic        ok,
   output logic [31:0] left
);
   logic [63:0] prod_ff;
   logic        wrap_ff;
   logic [31:0] tok_ff, burst_ff;
   logic [32:0] refill, total, capped;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= 64'(now - stamp) * 64'(rate);
         wrap_ff <= now < stamp;
         tok_ff <= tokens;
         burst_ff <= burst;
      end
   end

   always_comb begin
      refill = (wrap_ff || prod_ff > 64'(burst_ff)) ? {1'b0, burst_ff} : {1'b0, prod_ff[31:0]};
      total = {1'b0, tok_ff} + refill;
      capped = (total > {1'b0, burst_ff}) ? {1'b0, burst_ff} : total;
      ok = capped >= ONE_TOKEN;
      left = 32'(capped - ONE_TOKEN);
   end
endmodule

@@ design/per_source_token_bucket_limiter.sv @@
// Channel  | Ports                                        | Handshake
// request  | req_acl_allowed, req_addr_*, req_now_tick    | start & !busy
// response | rsp_verdict, rsp_insert_failed               | rsp_valid, one cycle
// config   | csr_index, csr_data                          | csr_valid & csr_ready
//
// A limited beat: the held key is searched along the row of cells one cell per
// cycle, the refill product and the search result are registered, then a token
// is spent if there is one and the bucket written back as the result registers.
// busy stays high through the result, so a new beat is taken only once the
// last one is done. A bypassed beat skips the search and the refill.
// Reset clears the valid marks of all cells at once; no clearing pass.
// The receiver cannot stall; busy holds off requests until after the result.
module per_source_token_bucket_limiter import pstb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_acl_allowed,
   input  logic [7:0]  req_addr_family,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [31:0] req_now_tick,
   output logic        rsp_valid,
   output logic        rsp_verdict,
   output logic        rsp_insert_failed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic        en_ff;
   logic [31:0] rate_ff, burst_ff;
   logic [7:0]  fam_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [31:0] now_ff;
   logic        bypass_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   state_type   state_ff, state_in;
   logic        rv_ff, rv_in, verd_ff, verd_in, fail_ff, fail_in;
   scan_type    chain [TABLE_ENTRIES+1];
   scan_type    res_ff;
   upd_type     upd;
   logic        load, ok;
   logic [31:0] left, src_tok, src_stamp;

   assign csr_ready = 1'b1;
   assign busy = state_ff != ST_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         rate_ff <= '0;
         burst_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LIMIT_ENABLE: en_ff <= csr_data[0];
            CSR_REFILL_RATE:  rate_ff <= csr_data;
            CSR_BURST_LIMIT:  burst_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Launch the search token into the first cell once the key is held.
   always_comb begin
      chain[0] = '0;
      chain[0].active = state_ff == ST_SCAN && cnt_ff == CNT_W'(1) && !bypass_ff;
   end

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      pstb_cell u_cell (
         .clock(clock), .reset(reset), .my_idx(IDX_W'(i)),
         .key_fam(fam_ff), .key_hi(hi_ff), .key_lo(lo_ff),
         .scan_i(chain[i]), .scan_o(chain[i+1]), .upd(upd)
      );
   end

   // Hit: refill the stored bucket; miss: a full bucket stamped now.
   assign src_tok = chain[TABLE_ENTRIES].found ? chain[TABLE_ENTRIES].tokens : burst_ff;
   assign src_stamp = chain[TABLE_ENTRIES].found ? chain[TABLE_ENTRIES].stamp : now_ff;
   assign load = state_ff == ST_SCAN && cnt_ff == CNT_W'(TABLE_ENTRIES + 1);

   pstb_refill u_refill (
      .clock(clock), .rate(rate_ff), .burst(burst_ff), .tokens(src_tok),
      .stamp(src_stamp), .now(now_ff), .load(load), .ok(ok), .left(left)
   );

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         fam_ff <= req_addr_family;
         hi_ff <= req_addr_hi;
         lo_ff <= req_addr_lo;
         now_ff <= req_now_tick;
         bypass_ff <= !en_ff || req_acl_allowed;
      end
      if (load) begin
         res_ff <= chain[TABLE_ENTRIES];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rv_in = 1'b0;
      verd_in = 1'b0;
      fail_in = 1'b0;
      upd = '0;
      upd.tokens = left;
      upd.stamp = now_ff;
      upd.new_key = !res_ff.found;
      upd.idx = res_ff.found ? res_ff.hit_idx : res_ff.free_idx;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = CNT_W'(1);
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (bypass_ff) begin
               rv_in = 1'b1;
               state_in = ST_DONE;
            end else if (cnt_ff == CNT_W'(TABLE_ENTRIES + 1)) begin
               state_in = ST_CALC;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_CALC: begin
            rv_in = 1'b1;
            verd_in = !ok;
            fail_in = ok && !res_ff.found && !res_ff.has_free;
            upd.we = ok && (res_ff.found || res_ff.has_free);
            state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         cnt_ff <= cnt_in;
      end
      verd_ff <= verd_in;
      fail_ff <= fail_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_verdict = verd_ff;
   assign rsp_insert_failed = fail_ff;
endmodule

@@ design/pstb_checker.sv @@
`include "assert_macros.svh"
module pstb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_verdict,
   input logic rsp_insert_failed
);
   // A verdict of drop never comes with a failed insert.
   `ASSERT_IMPL(a_excl, clock, reset, rsp_valid, !(rsp_verdict && rsp_insert_failed), "drop and fail")
   // An accepted beat makes the block busy.
   `ASSERT_NEXT(a_busy, clock, reset, start && !busy, busy, "not busy after accept")
   // A result is only shown while busy.
   `ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, busy, "result while idle")
   // Results last a single cycle.
   `ASSERT_NEXT(a_pulse, clock, reset, rsp_valid, !rsp_valid, "result held")
endmodule

bind per_source_token_bucket_limiter pstb_checker u_pstb_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_verdict(rsp_verdict), .rsp_insert_failed(rsp_insert_failed)
);
